@@ sv/htwd_pkg.sv @@
// ----------------------------------------------------------------------------
// Host word demultiplexer package
// Shared types and constants for the host transmit word demultiplexer.
// ----------------------------------------------------------------------------
package htwd_pkg;

  localparam int unsigned WordWidth  = 24;
  localparam int unsigned CountWidth = 12;
  localparam int unsigned MaxResults = 3;

  localparam logic [WordWidth-1:0] WordCancel    = 24'hF4F4F4;
  localparam logic [WordWidth-1:0] WordStatus    = 24'hF50000;
  localparam logic [WordWidth-1:0] WordDump      = 24'hF400F4;
  localparam logic [WordWidth-1:0] WordBootFirst = 24'hF40000;
  localparam logic [WordWidth-1:0] WordBootNext  = 24'h7F0000;
  localparam logic [7:0]           ByteMsgStart  = 8'hF0;
  localparam logic [7:0]           ByteMsgEnd    = 8'hF7;

  typedef enum logic [2:0] {
    KIND_MSG    = 3'd0,
    KIND_PRESET = 3'd1,
    KIND_STATUS = 3'd2,
    KIND_BOOT   = 3'd3,
    KIND_ABORT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_STATUS_COUNT = 2'd0,
    CFG_DROP_FOURTH  = 2'd1,
    CFG_MULTI_BYTES  = 2'd2,
    CFG_SINGLE_BYTES = 2'd3
  } cfg_index_e;

  typedef struct packed {
    kind_e                kind;
    logic [WordWidth-1:0] payload;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [1:0]               count;
    result_t [MaxResults-1:0] res;
  } entry_t;

  typedef struct packed {
    logic [1:0]            status_count;
    logic                  drop_fourth;
    logic [CountWidth-1:0] multi_bytes;
    logic [CountWidth-1:0] single_bytes;
  } cfg_t;

endpackage

@@ sv/host_tx_word_demultiplexer.sv @@
// ----------------------------------------------------------------------------
// Host transmit word demultiplexer
// Sorts 24-bit words sent by a DSP to its host into message bytes, preset
// dump bytes, status words, boot events and message aborts.
//
// Input channel: in_valid_i with in_stall_o; an item is a command bit, a
// host word and a requested preset byte count. Output channel: out_valid_o
// with out_stall_i; each result carries kind, payload and last.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and data;
// writes are taken in every cycle and are meant for an idle block.
// An accepted item produces zero to three results. The front end classifies
// it in its accept cycle and queues the bundle; the back end sends one
// result per cycle, while the receiver does not stall, via a current-bundle
// register and the output register. Items are accepted every cycle while the
// two-entry queue has room; a preset word with three bytes yields three
// results, so the sustained item rate falls as results per item grow.
// When the receiver stalls, the output register holds its result and the
// queue fills, after which in_stall_o rises. Reset empties the queue and
// output, returns parsing to idle and loads the register defaults.
// ----------------------------------------------------------------------------
module host_tx_word_demultiplexer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [htwd_pkg::CountWidth-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [htwd_pkg::WordWidth-1:0]  host_word_i,
  input  logic [htwd_pkg::CountWidth-1:0] request_bytes_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      kind_o,
  output logic [htwd_pkg::WordWidth-1:0]  payload_o,
  output logic                            last_o
);
  import htwd_pkg::*;

  cfg_t   cfg_q;
  logic   queue_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_valid;
  entry_t q_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.status_count <= 2'd2;
      cfg_q.drop_fourth  <= 1'b0;
      cfg_q.multi_bytes  <= CountWidth'(256);
      cfg_q.single_bytes <= CountWidth'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_STATUS_COUNT: cfg_q.status_count <= cfg_data_i[1:0];
        CFG_DROP_FOURTH:  cfg_q.drop_fourth  <= cfg_data_i[0];
        CFG_MULTI_BYTES:  cfg_q.multi_bytes  <= cfg_data_i;
        CFG_SINGLE_BYTES: cfg_q.single_bytes <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  htwd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .host_word_i     (host_word_i),
    .request_bytes_i (request_bytes_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  htwd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  htwd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .payload_o   (payload_o),
    .last_o      (last_o)
  );

endmodule

@@ sv/htwd_front.sv @@
// ----------------------------------------------------------------------------
// Host word demultiplexer front end
// Accepts commands and host words, runs the parse state machine and builds
// a bundle of up to three results for each accepted item.
// ----------------------------------------------------------------------------
module htwd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  htwd_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [htwd_pkg::WordWidth-1:0] host_word_i,
  input  logic [htwd_pkg::CountWidth-1:0] request_bytes_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output htwd_pkg::entry_t               entry_o
);
  import htwd_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_MESSAGE = 2'd1,
    MODE_PRESET  = 2'd2,
    MODE_STATUS  = 2'd3
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [CountWidth-1:0] preset_rem_q, preset_rem_d;
  logic                  size_unknown_q, size_unknown_d;
  logic [1:0]            status_rem_q, status_rem_d;
  logic [1:0]            msg_idx_q, msg_idx_d;
  logic                  pat_pos_q, pat_pos_d;

  logic                  accept;
  logic                  do_idle;
  logic [1:0]            n;
  logic [CountWidth-1:0] rem;
  logic [1:0]            srem;
  logic [1:0]            idx_next;
  logic [7:0]            top;
  logic                  match;
  result_t [MaxResults-1:0] res;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign top        = host_word_i[WordWidth-1 -: 8];

  always_comb begin
    mode_d         = mode_q;
    preset_rem_d   = preset_rem_q;
    size_unknown_d = size_unknown_q;
    status_rem_d   = status_rem_q;
    msg_idx_d      = msg_idx_q;
    pat_pos_d      = pat_pos_q;
    do_idle        = 1'b0;
    n              = 2'd0;
    rem            = preset_rem_q;
    srem           = status_rem_q;
    idx_next       = msg_idx_q + 2'd1;
    match          = 1'b0;
    res            = '0;

    if (accept) begin
      if (command_i) begin
        preset_rem_d   = request_bytes_i;
        size_unknown_d = 1'b0;
      end else begin
        case (mode_q)
          MODE_IDLE: begin
            do_idle = 1'b1;
          end
          MODE_MESSAGE: begin
            if (host_word_i[15:0] != 16'd0) begin
              mode_d = MODE_IDLE;
              res[0] = '{kind: KIND_ABORT, payload: '0, last: 1'b0};
              n       = 2'd1;
              do_idle = 1'b1;
            end else begin
              msg_idx_d = idx_next;
              if (!(cfg_i.drop_fourth && idx_next == 2'd0)) begin
                if (top == ByteMsgEnd) begin
                  mode_d = MODE_IDLE;
                  res[0] = '{kind: KIND_MSG, payload: WordWidth'(top), last: 1'b1};
                end else begin
                  res[0] = '{kind: KIND_MSG, payload: WordWidth'(top), last: 1'b0};
                end
                n = 2'd1;
              end
            end
          end
          MODE_PRESET: begin
            if (size_unknown_q) begin
              rem = (top == 8'd1 || top == 8'd2) ? cfg_i.multi_bytes : cfg_i.single_bytes;
            end
            size_unknown_d = 1'b0;
            for (int i = 0; i < MaxResults; i++) begin
              if (rem != '0) begin
                rem    = rem - CountWidth'(1);
                res[i] = '{kind: KIND_PRESET,
                           payload: WordWidth'(host_word_i[WordWidth-1-8*i -: 8]),
                           last: (rem == '0)};
                n      = n + 2'd1;
              end
            end
            preset_rem_d = rem;
            if (rem == '0) begin
              mode_d = MODE_IDLE;
            end
          end
          default: begin
            if (srem != 2'd0) begin
              srem = srem - 2'd1;
            end
            status_rem_d = srem;
            if (srem == 2'd0) begin
              mode_d = MODE_IDLE;
            end
            res[0] = '{kind: KIND_STATUS, payload: host_word_i, last: (srem == 2'd0)};
            n      = 2'd1;
          end
        endcase

        if (do_idle) begin
          if (host_word_i == WordCancel) begin
            preset_rem_d   = '0;
            size_unknown_d = 1'b0;
          end else if (host_word_i == WordStatus) begin
            mode_d       = MODE_STATUS;
            status_rem_d = (cfg_i.status_count == 2'd0) ? 2'd1 : cfg_i.status_count;
          end else if (host_word_i == WordDump) begin
            mode_d = MODE_PRESET;
            if (preset_rem_q == '0) begin
              size_unknown_d = 1'b1;
            end
          end else if (top == ByteMsgStart) begin
            mode_d    = MODE_MESSAGE;
            msg_idx_d = 2'd1;
            res[n]    = '{kind: KIND_MSG, payload: WordWidth'(top), last: 1'b0};
            n         = n + 2'd1;
          end else begin
            match = pat_pos_q ? (host_word_i == WordBootNext)
                              : (host_word_i == WordBootFirst);
            if (match && pat_pos_q) begin
              pat_pos_d = 1'b0;
              res[n]    = '{kind: KIND_BOOT, payload: '0, last: 1'b0};
              n         = n + 2'd1;
            end else begin
              pat_pos_d = match;
            end
          end
        end
      end
    end
  end

  assign push_o        = accept && !command_i && (n != 2'd0);
  assign entry_o.count = n;
  assign entry_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_IDLE;
      preset_rem_q   <= '0;
      size_unknown_q <= 1'b0;
      status_rem_q   <= 2'd0;
      msg_idx_q      <= 2'd0;
      pat_pos_q      <= 1'b0;
    end else begin
      mode_q         <= mode_d;
      preset_rem_q   <= preset_rem_d;
      size_unknown_q <= size_unknown_d;
      status_rem_q   <= status_rem_d;
      msg_idx_q      <= msg_idx_d;
      pat_pos_q      <= pat_pos_d;
    end
  end

endmodule

@@ sv/htwd_queue.sv @@
// ----------------------------------------------------------------------------
// Host word demultiplexer result queue
// Two-entry queue of result bundles between the front end and the back end.
// ----------------------------------------------------------------------------
module htwd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  htwd_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output htwd_pkg::entry_t entry_o
);
  import htwd_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ sv/htwd_back.sv @@
// ----------------------------------------------------------------------------
// Host word demultiplexer back end
// Takes result bundles from the queue and sends them out one result per
// cycle, while the receiver does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
module htwd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  htwd_pkg::entry_t               q_entry_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     kind_o,
  output logic [htwd_pkg::WordWidth-1:0] payload_o,
  output logic                           last_o
);
  import htwd_pkg::*;

  entry_t     cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       advance;
  logic       cur_done;
  logic       cur_free;

  assign advance  = !out_valid_q || !out_stall_i;
  assign cur_done = advance && cur_valid_q && (idx_q + 2'd1 == cur_q.count);
  assign cur_free = !cur_valid_q || cur_done;
  assign pop_o    = q_valid_i && cur_free;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_entry_i;
    end
    if (advance && cur_valid_q) begin
      out_q <= cur_q.res[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= cur_valid_q;
      end
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (cur_done) begin
        cur_valid_q <= 1'b0;
        idx_q       <= 2'd0;
      end else if (advance && cur_valid_q) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign payload_o   = out_q.payload;
  assign last_o      = out_q.last;

endmodule

@@ verif/host_tx_word_demultiplexer_tb.sv @@
// ----------------------------------------------------------------------------
// Host transmit word demultiplexer testbench
// Feeds host words and preset requests through a randomly idling driver,
// predicts the message, preset, status, boot and abort results in a local
// model of the parser, and checks every result the block sends. The run
// covers a directed part and three random phases with different register
// settings, a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module host_tx_word_demultiplexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htwd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;
  localparam int LongHold    = 300;
  localparam int PhaseItems  = 40;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_MESSAGE,
    PARSE_PRESET,
    PARSE_STATUS
  } parse_e;

  typedef struct {
    bit                    command;
    logic [WordWidth-1:0]  word;
    logic [CountWidth-1:0] req;
    bit                    pause;
  } host_item_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic [1:0]            cfg_index_i     = '0;
  logic [CountWidth-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  command_i       = 1'b0;
  logic [WordWidth-1:0]  host_word_i     = '0;
  logic [CountWidth-1:0] request_bytes_i = '0;
  logic                  out_stall_i     = 1'b0;
  logic                  cfg_ready_o;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [2:0]            kind_o;
  logic [WordWidth-1:0]  payload_o;
  logic                  last_o;

  parse_e                parse_mode   = PARSE_IDLE;
  logic [CountWidth-1:0] preset_left  = '0;
  bit                    size_pending = 1'b0;
  logic [1:0]            status_left  = '0;
  logic [1:0]            msg_index    = '0;
  bit                    boot_pos     = 1'b0;

  logic [1:0]            cfg_status = 2'd2;
  bit                    cfg_drop   = 1'b0;
  logic [CountWidth-1:0] cfg_multi  = 12'd256;
  logic [CountWidth-1:0] cfg_single = 12'd256;

  host_item_t pending_items[$];
  result_t    expected_results[$];
  host_item_t next_item;
  result_t    want_result;

  int cycle_count    = 0;
  int error_count    = 0;
  int queued_count   = 0;
  int accepted_count = 0;
  int in_gap_left    = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  int long_hold_at   = -1;
  bit hold_done      = 1'b0;
  bit pause_next     = 1'b0;
  bit in_gaps_on     = 1'b1;
  bit out_gaps_on    = 1'b1;

  host_tx_word_demultiplexer dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %0s", cycle_count, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_result(kind_e k, logic [WordWidth-1:0] p, bit l);
    result_t r;
    r.kind = k;
    r.payload = p;
    r.last = l;
    expected_results = {expected_results, r};
  endfunction

  function automatic void parse_idle_word(logic [WordWidth-1:0] w);
    if (w == WordCancel) begin
      preset_left = '0;
      size_pending = 1'b0;
    end else if (w == WordStatus) begin
      parse_mode = PARSE_STATUS;
      status_left = (cfg_status == 2'd0) ? 2'd1 : cfg_status;
    end else if (w == WordDump) begin
      parse_mode = PARSE_PRESET;
      if (preset_left == '0) size_pending = 1'b1;
    end else if (w[23:16] == ByteMsgStart) begin
      parse_mode = PARSE_MESSAGE;
      msg_index = 2'd1;
      push_result(KIND_MSG, {16'h0, w[23:16]}, 1'b0);
    end else if (w == (boot_pos ? WordBootNext : WordBootFirst)) begin
      if (boot_pos) begin
        boot_pos = 1'b0;
        push_result(KIND_BOOT, '0, 1'b0);
      end else begin
        boot_pos = 1'b1;
      end
    end else begin
      boot_pos = 1'b0;
    end
  endfunction

  function automatic void predict_item(bit cmd, logic [WordWidth-1:0] w,
                                       logic [CountWidth-1:0] req);
    int i;
    if (cmd) begin
      preset_left = req;
      size_pending = 1'b0;
      return;
    end
    case (parse_mode)
      PARSE_IDLE: begin
        parse_idle_word(w);
      end
      PARSE_MESSAGE: begin
        if (w[15:0] != 16'h0) begin
          parse_mode = PARSE_IDLE;
          push_result(KIND_ABORT, '0, 1'b0);
          parse_idle_word(w);
        end else begin
          msg_index = msg_index + 2'd1;
          if (!(cfg_drop && msg_index == 2'd0)) begin
            if (w[23:16] == ByteMsgEnd) begin
              parse_mode = PARSE_IDLE;
              push_result(KIND_MSG, {16'h0, w[23:16]}, 1'b1);
            end else begin
              push_result(KIND_MSG, {16'h0, w[23:16]}, 1'b0);
            end
          end
        end
      end
      PARSE_PRESET: begin
        if (size_pending) begin
          size_pending = 1'b0;
          preset_left = (w[23:16] == 8'd1 || w[23:16] == 8'd2) ? cfg_multi : cfg_single;
        end
        for (i = 0; i < 3; i++) begin
          if (preset_left != '0) begin
            preset_left = preset_left - CountWidth'(1);
            push_result(KIND_PRESET, {16'h0, w[23-8*i -: 8]}, preset_left == '0);
          end
        end
        if (preset_left == '0) parse_mode = PARSE_IDLE;
      end
      default: begin
        if (status_left != 2'd0) status_left = status_left - 2'd1;
        if (status_left == 2'd0) parse_mode = PARSE_IDLE;
        push_result(KIND_STATUS, w, status_left == 2'd0);
      end
    endcase
  endfunction

  function automatic void add_word(logic [WordWidth-1:0] w);
    host_item_t it;
    it.command = 1'b0;
    it.word = w;
    it.req = CountWidth'($urandom);
    it.pause = pause_next;
    pending_items = {pending_items, it};
    pause_next = 1'b0;
    queued_count++;
  endfunction

  function automatic void add_request(logic [CountWidth-1:0] req);
    host_item_t it;
    it.command = 1'b1;
    it.word = WordWidth'($urandom);
    it.req = req;
    it.pause = pause_next;
    pending_items = {pending_items, it};
    pause_next = 1'b0;
    queued_count++;
  endfunction

  function automatic void add_sequence();
    int unsigned r;
    int unsigned n;
    int unsigned len;
    logic [7:0] b;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      add_word({ByteMsgStart, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0});
      n = $urandom_range(0, 6);
      repeat (n) begin
        b = 8'($urandom);
        if (b == ByteMsgEnd) b = 8'h00;
        add_word({b, 16'h0});
      end
      case ($urandom_range(0, 9))
        0: add_word({8'($urandom), 16'($urandom_range(1, 65535))});
        1: add_word(WordCancel);
        2: begin
          add_word({ByteMsgStart, 16'($urandom_range(1, 65535))});
          add_word({ByteMsgEnd, 16'h0});
        end
        3: ;
        default: add_word({ByteMsgEnd, 16'h0});
      endcase
    end else if (r < 50) begin
      len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      add_request(CountWidth'(len));
      add_word(WordDump);
      n = (len == 0) ? 1 : (len + 2) / 3;
      repeat (n) add_word(WordWidth'($urandom));
    end else if (r < 68) begin
      code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 2)) : 8'($urandom);
      len = (code == 8'd1 || code == 8'd2) ? cfg_multi : cfg_single;
      if (len > 30) begin
        code = (code == 8'd1 || code == 8'd2) ? 8'($urandom_range(3, 255)) : 8'd1;
        len = (code == 8'd1) ? cfg_multi : cfg_single;
        if (len > 30) return;
      end
      add_word(WordCancel);
      add_word(WordDump);
      add_word({code, 16'($urandom)});
      n = (len == 0) ? 1 : (len + 2) / 3;
      repeat (n - 1) add_word(WordWidth'($urandom));
    end else if (r < 80) begin
      add_word(WordStatus);
      n = (cfg_status == 2'd0) ? 1 : cfg_status;
      repeat (n) add_word(WordWidth'($urandom));
    end else if (r < 90) begin
      add_word(WordBootFirst);
      if ($urandom_range(0, 2) == 0) add_word(WordWidth'($urandom));
      add_word(WordBootNext);
    end else if ($urandom_range(0, 1) == 0) begin
      add_request(CountWidth'($urandom));
    end else begin
      add_word(WordWidth'($urandom));
    end
  endfunction

  function automatic void fill_random(int count);
    int target;
    target = queued_count + count;
    while (queued_count < target) add_sequence();
  endfunction

  task automatic write_register(cfg_index_e idx, logic [CountWidth-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_STATUS_COUNT: cfg_status = value[1:0];
      CFG_DROP_FOURTH:  cfg_drop = value[0];
      CFG_MULTI_BYTES:  cfg_multi = value;
      default:          cfg_single = value;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_registers(logic [1:0] status_count, bit drop,
                               logic [CountWidth-1:0] multi, logic [CountWidth-1:0] single);
    write_register(CFG_STATUS_COUNT, {10'h0, status_count});
    write_register(CFG_DROP_FOURTH, {11'h0, drop});
    write_register(CFG_MULTI_BYTES, multi);
    write_register(CFG_SINGLE_BYTES, single);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_item(command_i, host_word_i, request_bytes_i);
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].pause && expected_results.size() != 0)) begin
          next_item = pending_items.pop_front();
          command_i <= next_item.command;
          host_word_i <= next_item.word;
          request_bytes_i <= next_item.req;
          in_valid_i <= 1'b1;
          in_gap_left = in_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && long_hold_at >= 0 && accepted_count >= long_hold_at) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = out_gaps_on ? pick_gap() : 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d payload %06h last %0b",
                                  kind_o, payload_o, last_o));
      end else begin
        want_result = expected_results.pop_front();
        if (kind_o !== want_result.kind || payload_o !== want_result.payload ||
            last_o !== want_result.last) begin
          report_mismatch($sformatf("got kind %0d payload %06h last %0b, want %0d %06h %0b",
                                    kind_o, payload_o, last_o, want_result.kind,
                                    want_result.payload, want_result.last));
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_registers(2'd3, 1'b1, 12'd4095, 12'd5);
    add_request(12'd4095);
    add_word(WordDump);
    add_word(24'hFFFFFF);
    add_request(12'd1);
    add_word(24'h000000);
    add_word(WordDump);
    add_word(24'h01ABCD);
    add_request(12'd0);
    add_word(24'h123456);
    add_word(WordStatus);
    add_word(24'h000000);
    add_word(24'hFFFFFF);
    add_word(24'h123456);
    add_word(24'hF00000);
    add_word(24'h110000);
    add_word(24'h220000);
    add_word(24'h330000);
    add_word(24'hF70000);
    add_word(24'hF01234);
    add_word(WordCancel);
    add_word(WordBootFirst);
    add_word(24'h123456);
    add_word(WordBootNext);
    add_word(WordBootFirst);
    add_word(WordBootNext);
    wait_drained();

    set_registers(2'd1, 1'b0, 12'd7, 12'd1);
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    fill_random(PhaseItems);
    wait_drained();

    set_registers(2'd0, 1'b1, 12'd0, 12'd2);
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    long_hold_at = accepted_count + 15;
    fill_random(PhaseItems);
    wait_drained();

    set_registers(2'd3, 1'b1, 12'd12, 12'd4095);
    fill_random(PhaseItems / 2);
    pause_next = 1'b1;
    fill_random(PhaseItems / 2);
    wait_drained();

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
